[hw/rtl/psgm_pkg.sv]
`default_nettype none

package psgm_pkg;

	typedef enum logic [1:0] {
		OP_SELECT = 2'd0,
		OP_WRITE  = 2'd1,
		OP_READ   = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	localparam logic [3:0] REG_A_FINE    = 4'd0;
	localparam logic [3:0] REG_A_COARSE  = 4'd1;
	localparam logic [3:0] REG_B_FINE    = 4'd2;
	localparam logic [3:0] REG_B_COARSE  = 4'd3;
	localparam logic [3:0] REG_C_FINE    = 4'd4;
	localparam logic [3:0] REG_C_COARSE  = 4'd5;
	localparam logic [3:0] REG_NOISE     = 4'd6;
	localparam logic [3:0] REG_MIXER     = 4'd7;
	localparam logic [3:0] REG_VOL_A     = 4'd8;
	localparam logic [3:0] REG_VOL_B     = 4'd9;
	localparam logic [3:0] REG_VOL_C     = 4'd10;
	localparam logic [3:0] REG_ENV_FINE  = 4'd11;
	localparam logic [3:0] REG_ENV_CRS   = 4'd12;
	localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

	localparam int MAX_WORDS = 10;
	localparam logic [15:0] DIV10_RECIP = 16'hCCCD;
	localparam logic [7:0] NOISE_OFF = 8'hFF;

	typedef logic [15:0][7:0] rf_t;

	typedef struct packed {
		logic                        kind;
		logic [3:0]                  cnt;
		logic [MAX_WORDS-1:0][7:0]   bytes;
		logic                        act;
		logic [12:0]                 period;
	} job_t;

	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] b;
	} tone_t;

	function automatic logic [3:0] env_level(input logic [3:0] shape, input logic [4:0] step);
		logic [3:0] i;
		logic [3:0] r;
		i = step[3:0];
		if (!step[4]) begin
			r = shape[2] ? i : 4'd15 - i;
		end else begin
			case (shape)
				4'd8, 4'd14: r = 4'd15 - i;
				4'd10, 4'd12: r = i;
				4'd11, 4'd13: r = 4'd15;
				default: r = 4'd0;
			endcase
		end
		return r;
	endfunction

	function automatic tone_t tone_bytes(input logic [1:0] ch, input rf_t rf);
		tone_t t;
		logic [7:0] base;
		logic [15:0] p16;
		logic [10:0] p;
		logic [3:0] vol;
		base = {1'b1, ch, 5'b0};
		p16 = {rf[{ch, 1'b1}], rf[{ch, 1'b0}]};
		p = p16[11] ? 11'h7FF : p16[10:0];
		vol = rf[REG_VOL_A + {2'b0, ch}][3:0];
		t.b = '0;
		if (!rf[REG_MIXER][ch]) begin
			t.cnt = 2'd3;
			t.b[0] = base | {4'b0, p[3:0]};
			t.b[1] = {1'b0, p[10:4]};
			t.b[2] = (p != 11'd0) ? (base | 8'h10 | {4'b0, 4'd15 - vol}) : (base | 8'h1F);
		end else begin
			t.cnt = 2'd1;
			t.b[0] = base | 8'h1F;
		end
		return t;
	endfunction

	function automatic logic [7:0] noise_byte(input rf_t rf);
		logic [7:0] r;
		logic [3:0] vol;
		r = NOISE_OFF;
		for (int c = 2; c >= 0; c--) begin
			vol = rf[REG_VOL_A + 4'(c)][3:0];
			if (!rf[REG_MIXER][3 + c] && vol != 4'd0) begin
				r = 8'hF0 | {4'b0, 4'd15 - vol};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/psgm_front.sv]
`default_nettype none

module psgm_front import psgm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [1:0] op,
	input  wire logic [7:0] value,
	output job_t            job,
	output logic            push
);

	logic [7:0]  sel_q;
	rf_t         rf_q;
	logic [2:0][4:0] step_q;
	logic        flag_q;
	logic [12:0] period_q;

	rf_t         rf_n;
	logic [2:0][4:0] step_n;
	logic        flag_n;
	logic [12:0] period_n;
	logic [31:0] prod;
	logic [2:0]  tone_en;
	logic        noise_en;
	logic        pre_en;
	logic [7:0]  pre_byte;
	logic        rd;
	logic        period_wr;
	logic        changed;
	logic [3:0]  idx;
	logic [3:0]  shape;
	logic [3:0]  lvl;
	logic [4:0]  np;
	logic [3:0]  n;
	logic [MAX_WORDS-1:0][7:0] b;
	tone_t       t;

	assign idx = sel_q[3:0];
	assign shape = rf_q[REG_ENV_SHAPE][3:0];

	always_comb begin
		rf_n = rf_q;
		step_n = step_q;
		flag_n = flag_q;
		tone_en = 3'b000;
		noise_en = 1'b0;
		pre_en = 1'b0;
		pre_byte = 8'hE1;
		rd = 1'b0;
		period_wr = 1'b0;
		changed = 1'b0;
		lvl = 4'd0;
		np = value[4:0];
		case (op_t'(op))
			OP_SELECT: begin
			end
			OP_READ: begin
				rd = 1'b1;
			end
			OP_WRITE: begin
				if (sel_q[7:4] == 4'd0) begin
					rf_n[idx] = value;
					case (idx)
						REG_A_FINE, REG_A_COARSE: tone_en = 3'b001;
						REG_B_FINE, REG_B_COARSE: tone_en = 3'b010;
						REG_C_FINE, REG_C_COARSE: tone_en = 3'b100;
						REG_NOISE: begin
							pre_en = 1'b1;
							noise_en = 1'b1;
							if (np > 5'd28) pre_byte = 8'hE6;
							else if (np > 5'd20) pre_byte = 8'hE5;
							else if (np > 5'd12) pre_byte = 8'hE4;
							else if (np > 5'd8) pre_byte = 8'hE3;
							else if (np > 5'd4) pre_byte = 8'hE2;
						end
						REG_MIXER: begin
							tone_en = 3'b111;
							noise_en = 1'b1;
						end
						REG_VOL_A, REG_VOL_B, REG_VOL_C: begin
							if (value[4]) begin
								rf_n[idx] = value & (8'hF0 | {4'b0, rf_q[idx][3:0]});
								flag_n = 1'b1;
							end else begin
								flag_n = rf_n[REG_VOL_A][4] | rf_n[REG_VOL_B][4]
									| rf_n[REG_VOL_C][4];
								tone_en = 3'b001 << (idx - REG_VOL_A);
								noise_en = 1'b1;
							end
						end
						REG_ENV_FINE, REG_ENV_CRS: period_wr = 1'b1;
						REG_ENV_SHAPE: step_n = '0;
						default: begin
						end
					endcase
				end
			end
			OP_TICK: begin
				for (int c = 0; c < 3; c++) begin
					if (rf_q[REG_VOL_A + 4'(c)][4]) begin
						lvl = env_level(shape, step_q[c]);
						if (lvl != rf_q[REG_VOL_A + 4'(c)][3:0]) begin
							rf_n[REG_VOL_A + 4'(c)][3:0] = lvl;
							changed = 1'b1;
						end
						if (step_q[c] == 5'd31) begin
							step_n[c] = (shape[3] && !shape[0]) ? 5'd0 : 5'd31;
						end else begin
							step_n[c] = step_q[c] + 5'd1;
						end
					end
				end
				if (changed) begin
					tone_en = 3'b111;
					noise_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign prod = {rf_n[REG_ENV_CRS], rf_n[REG_ENV_FINE]} * DIV10_RECIP;
	assign period_n = period_wr ? prod[31:19] : period_q;

	always_comb begin
		b = '0;
		n = 4'd0;
		t = '0;
		if (rd) begin
			b[0] = (sel_q[7:4] == 4'd0) ? rf_q[idx] : 8'h00;
			n = 4'd1;
		end
		if (pre_en) begin
			b[n] = pre_byte;
			n = n + 4'd1;
		end
		for (int c = 0; c < 3; c++) begin
			if (tone_en[c]) begin
				t = tone_bytes(2'(c), rf_n);
				for (int j = 0; j < 3; j++) begin
					if (2'(j) < t.cnt) begin
						b[n] = t.b[j];
						n = n + 4'd1;
					end
				end
			end
		end
		if (noise_en) begin
			b[n] = noise_byte(rf_n);
			n = n + 4'd1;
		end
	end

	assign job.kind = rd;
	assign job.cnt = n;
	assign job.bytes = b;
	assign job.act = flag_n;
	assign job.period = period_n;
	assign push = take && (n != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
			rf_q <= '0;
			step_q <= '0;
			flag_q <= 1'b0;
			period_q <= '0;
		end else if (take) begin
			if (op_t'(op) == OP_SELECT) begin
				sel_q <= value;
			end
			rf_q <= rf_n;
			step_q <= step_n;
			flag_q <= flag_n;
			period_q <= period_n;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/psgm_fifo.sv]
`default_nettype none

module psgm_fifo import psgm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      din,
	input  wire logic pop,
	output job_t      dout,
	output logic      full,
	output logic      empty
);

	job_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

[hw/rtl/psgm_back.sv]
`default_nettype none

module psgm_back import psgm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  job_t            head,
	input  wire logic       empty,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            kind,
	output logic [7:0]      data_byte,
	output logic            last,
	output logic            envelope_active,
	output logic [12:0]     envelope_period_out
);

	logic [3:0] k_q;
	logic       fire;

	assign out_valid = !empty;
	assign kind = head.kind;
	assign data_byte = head.bytes[k_q];
	assign last = (k_q == head.cnt - 4'd1);
	assign envelope_active = head.act;
	assign envelope_period_out = head.period;
	assign fire = out_valid && !out_stall;
	assign pop = fire && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 4'd0;
		end else if (fire) begin
			k_q <= last ? 4'd0 : k_q + 4'd1;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/psg_register_to_sn_command_mapper.sv]
`default_nettype none

// Translates accesses to a sixteen-register three-channel sound generator into command
// words for a four-channel tone chip. The front end takes one access per cycle unless the input
// stalls, updates the register file in that cycle and queues the whole list of words it causes.
// The back end offers the first word once the access is queued and older words have drained,
// and sends one word per cycle while out_stall is low, up to ten words for one access. An
// access that causes no word is not queued. A two-entry queue lets new accesses arrive
// while older words drain, and the input stalls while both entries are occupied.

module psg_register_to_sn_command_mapper import psgm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [7:0]       data_byte,
	output logic             last,
	output logic             envelope_active,
	output logic [12:0]      envelope_period_out
);

	job_t job;
	job_t head;
	logic push;
	logic pop;
	logic full;
	logic empty;
	logic take;

	assign in_stall = full;
	assign take = in_valid && !full;

	psgm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.op     (op),
		.value  (value),
		.job    (job),
		.push   (push)
	);

	psgm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (job),
		.pop    (pop),
		.dout   (head),
		.full   (full),
		.empty  (empty)
	);

	psgm_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.head                (head),
		.empty               (empty),
		.pop                 (pop),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.kind                (kind),
		.data_byte           (data_byte),
		.last                (last),
		.envelope_active     (envelope_active),
		.envelope_period_out (envelope_period_out)
	);

`ifndef NO_ASSERTIONS
	a_read_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> last) else $error("read data word is not last");
	a_period_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> envelope_period_out <= 13'd6553) else $error("period out of range");
	a_read_queued: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op == OP_READ |=> out_valid) else $error("read lost");
`endif

endmodule

`default_nettype wire

[dv/psg_register_to_sn_command_mapper_tb.sv]
`default_nettype none

module psg_register_to_sn_command_mapper_tb;
	import psgm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic        last;
		logic        act;
		logic [12:0] period;
	} word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [7:0]  value;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic [7:0]  data_byte;
	logic        last;
	logic        envelope_active;
	logic [12:0] envelope_period_out;

	psg_register_to_sn_command_mapper u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .data_byte(data_byte), .last(last),
		.envelope_active(envelope_active), .envelope_period_out(envelope_period_out)
	);

	logic [7:0]  m_sel;
	logic [7:0]  m_regs [16];
	logic [4:0]  m_step [3];
	logic        m_env_on;
	logic [12:0] m_env_period;
	logic [7:0]  cmd_list [$];

	word_t expected_words [$];
	int    error_count = 0;
	int    items_sent;
	int    words_seen = 0;
	int    idle_cycles = 0;
	int    stall_mode = 1;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [3:0] table_level(input logic [3:0] shape, input logic [4:0] step);
		logic [3:0] i;
		i = step[3:0];
		if (step < 5'd16) return shape[2] ? i : 4'd15 - i;
		case (shape)
			4'd8, 4'd14: return 4'd15 - i;
			4'd10, 4'd12: return i;
			4'd11, 4'd13: return 4'd15;
			default: return 4'd0;
		endcase
	endfunction

	task automatic push_tone(input int ch);
		logic [7:0]  base;
		logic [15:0] p;
		base = 8'h80 + 8'(32 * ch);
		if (!m_regs[REG_MIXER][ch]) begin
			p = {m_regs[2*ch+1], m_regs[2*ch]};
			p = p[11] ? 16'h7FF : (p & 16'h7FF);
			cmd_list.push_back(base | {4'b0, p[3:0]});
			cmd_list.push_back({1'b0, p[10:4]});
			if (p != 0)
				cmd_list.push_back((base + 8'h10) | {4'b0, 4'd15 - m_regs[8+ch][3:0]});
			else
				cmd_list.push_back(base + 8'h1F);
		end else begin
			cmd_list.push_back(base + 8'h1F);
		end
	endtask

	task automatic push_noise();
		for (int c = 0; c < 3; c++) begin
			if (!m_regs[REG_MIXER][3+c] && m_regs[8+c][3:0] != 4'd0) begin
				cmd_list.push_back(8'hF0 | {4'b0, 4'd15 - m_regs[8+c][3:0]});
				return;
			end
		end
		cmd_list.push_back(NOISE_OFF);
	endtask

	task automatic push_all();
		push_tone(0);
		push_tone(1);
		push_tone(2);
		push_noise();
	endtask

	task automatic predict_access(input op_t o, input logic [7:0] v);
		logic       is_read;
		logic [7:0] prev;
		logic [4:0] np;
		logic [3:0] shape;
		logic [3:0] lvl;
		logic       changed;
		int         idx;
		is_read = 1'b0;
		cmd_list.delete();
		case (o)
			OP_SELECT: m_sel = v;
			OP_READ: begin
				is_read = 1'b1;
				cmd_list.push_back(m_sel < 16 ? m_regs[m_sel[3:0]] : 8'h00);
			end
			OP_WRITE: if (m_sel < 16) begin
				idx = m_sel;
				prev = m_regs[idx];
				m_regs[idx] = v;
				case (idx)
					0, 1: push_tone(0);
					2, 3: push_tone(1);
					4, 5: push_tone(2);
					6: begin
						np = v[4:0];
						if (np > 28) cmd_list.push_back(8'hE6);
						else if (np > 20) cmd_list.push_back(8'hE5);
						else if (np > 12) cmd_list.push_back(8'hE4);
						else if (np > 8) cmd_list.push_back(8'hE3);
						else if (np > 4) cmd_list.push_back(8'hE2);
						else cmd_list.push_back(8'hE1);
						push_noise();
					end
					7: push_all();
					8, 9, 10: begin
						if (v[4]) begin
							m_regs[idx] = m_regs[idx] & (8'hF0 | {4'b0, prev[3:0]});
							m_env_on = 1'b1;
						end else begin
							m_env_on = m_regs[8][4] | m_regs[9][4] | m_regs[10][4];
							push_tone(idx - 8);
							push_noise();
						end
					end
					11, 12: m_env_period = 13'(({m_regs[12], m_regs[11]}) / 16'd10);
					13: for (int c = 0; c < 3; c++) m_step[c] = 5'd0;
					default: ;
				endcase
			end
			default: begin
				shape = m_regs[REG_ENV_SHAPE][3:0];
				changed = 1'b0;
				for (int c = 0; c < 3; c++) begin
					if (m_regs[8+c][4]) begin
						lvl = table_level(shape, m_step[c]);
						if (lvl != m_regs[8+c][3:0]) begin
							m_regs[8+c][3:0] = lvl;
							changed = 1'b1;
						end
						if (m_step[c] == 5'd31)
							m_step[c] = ((shape & 4'h9) == 4'h8) ? 5'd0 : 5'd31;
						else
							m_step[c] = m_step[c] + 5'd1;
					end
				end
				if (changed) push_all();
			end
		endcase
		for (int k = 0; k < cmd_list.size(); k++)
			expected_words.push_back('{is_read, cmd_list[k], k == cmd_list.size() - 1,
				m_env_on, m_env_period});
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at word %0d: %s got %0h expected %0h", words_seen, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", data_byte, 0);
			end else begin
				word_t w;
				w = expected_words.pop_front();
				if (kind !== w.kind) report_mismatch("kind", kind, w.kind);
				if (data_byte !== w.data_byte) report_mismatch("data_byte", data_byte, w.data_byte);
				if (last !== w.last) report_mismatch("last", last, w.last);
				if (envelope_active !== w.act)
					report_mismatch("envelope_active", envelope_active, w.act);
				if (envelope_period_out !== w.period)
					report_mismatch("envelope_period_out", envelope_period_out, w.period);
			end
			words_seen++;
		end
	end

	always @(posedge clk) begin
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
		if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d words outstanding", expected_words.size());
			$display("[psg_register_to_sn_command_mapper] ERROR");
			$finish;
		end
	end

	int burst_left;

	task automatic send_access(input op_t o, input logic [7:0] v);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		op <= o;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_access(o, v);
		items_sent++;
		burst_left--;
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] v);
		send_access(OP_SELECT, idx);
		send_access(OP_WRITE, v);
	endtask

	task automatic test_directed();
		write_reg(REG_A_FINE, 8'hFF);
		write_reg(REG_A_COARSE, 8'h08);
		write_reg(REG_A_COARSE, 8'hF7);
		write_reg(REG_B_FINE, 8'h00);
		write_reg(REG_NOISE, 8'h1F);
		write_reg(REG_NOISE, 8'h03);
		write_reg(REG_MIXER, 8'hFF);
		write_reg(REG_MIXER, 8'h00);
		write_reg(REG_VOL_A, 8'h0F);
		write_reg(REG_VOL_B, 8'h1A);
		send_access(OP_READ, 8'h00);
		write_reg(REG_ENV_FINE, 8'hFF);
		write_reg(REG_ENV_CRS, 8'hFF);
		write_reg(REG_ENV_SHAPE, 8'h08);
		for (int k = 0; k < 4; k++) send_access(OP_TICK, 8'hFF);
		write_reg(8'd16, 8'h55);
		send_access(OP_READ, 8'h00);
		write_reg(8'hFF, 8'hAA);
		send_access(OP_READ, 8'h00);
	endtask

	task automatic test_random(input int count);
		logic [7:0] v;
		for (int n = 0; n < count; n++) begin
			v = $urandom_range(0, 255);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: write_reg($urandom_range(0, 9) == 0 ? v : 8'($urandom_range(0, 15)),
					8'($urandom_range(0, 255)));
				4, 5: send_access(OP_TICK, v);
				6: begin
					send_access(OP_SELECT, 8'($urandom_range(0, 17)));
					send_access(OP_READ, v);
				end
				7: write_reg(8'(8 + $urandom_range(0, 2)), {3'b0, 1'b1, 4'($urandom_range(0, 15))});
				8: write_reg(REG_ENV_SHAPE, v);
				default: send_access(op_t'($urandom_range(0, 3)), v);
			endcase
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_SELECT;
		value = 8'h00;
		items_sent = 0;
		burst_left = 0;
		m_sel = 8'h00;
		m_env_on = 1'b0;
		m_env_period = 13'd0;
		for (int i = 0; i < 16; i++) m_regs[i] = 8'h00;
		for (int c = 0; c < 3; c++) m_step[c] = 5'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(130);
		test_random(80);
		drain();
		$display("covered %0d accesses and %0d output words", items_sent, words_seen);
		$display("all register indexes, ticks, reads and out-of-range selects exercised");
		if (error_count == 0) begin
			$display("[psg_register_to_sn_command_mapper] OK");
		end else begin
			$display("%0d mismatches", error_count);
			$display("[psg_register_to_sn_command_mapper] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
